// ----- hw/rtl/uhcw_pkg.sv -----
package uhcw_pkg;

  localparam int unsigned ActionW   = 3;
  localparam int unsigned DecisionW = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [ActionW-1:0] ACT_BEGIN      = 3'd0;
  localparam logic [ActionW-1:0] ACT_SELF_CHECK = 3'd1;
  localparam logic [ActionW-1:0] ACT_UPDATE     = 3'd2;
  localparam logic [ActionW-1:0] ACT_CONFIRM    = 3'd3;
  localparam logic [ActionW-1:0] ACT_QUERY      = 3'd4;

  localparam logic [DecisionW-1:0] DEC_NONE        = 3'd0;
  localparam logic [DecisionW-1:0] DEC_NOT_PENDING = 3'd1;
  localparam logic [DecisionW-1:0] DEC_MARK_VALID  = 3'd2;
  localparam logic [DecisionW-1:0] DEC_ROLLBACK    = 3'd3;
  localparam logic [DecisionW-1:0] DEC_WAIT        = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_CONFIRM_MS    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GIVE_UP_MS    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SELF_CHECK_MS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HTTP_FRESH_MS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LINK_REQUIRED = 3'd4;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [31:0]        now_ms;
    logic               pending_verify;
    logic               web_started;
    logic               check_ok;
    logic               net_ok;
    logic               link_up;
    logic               user_requested;
  } in_item_t;

  typedef struct packed {
    logic [DecisionW-1:0] decision;
    logic                 confirmed;
    logic                 pending;
    logic                 self_check_due;
    logic                 http_ok;
    logic [2:0]           missing_checks;
    logic [31:0]          healthy_for_ms;
    logic [31:0]          remaining_ms;
  } out_item_t;

endpackage

// ----- hw/rtl/update_health_confirm_watchdog.sv -----
// Update health-confirm watchdog. Each input word is an event (begin, self-check
// result, update, confirm-before-restart, query) stamped with a wrapping 32-bit
// millisecond time; every event yields exactly one result word carrying the
// decision and the status after the event. An event is held in the input
// register, is evaluated in a single pass of compare/subtract logic that also
// updates the watchdog state, and lands in the output register; one event is
// taken every cycle as long as out_stall stays low.
// Throughput is set by that single evaluation pass, one event per clock while out_stall is low.
// Configuration is written through cfg_* (always ready); the user must write it only
// while no event is in flight, which the block itself does not enforce; indexes beyond the register list are ignored.
module update_health_confirm_watchdog (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  uhcw_pkg::in_item_t       in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output uhcw_pkg::out_item_t      out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [uhcw_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [uhcw_pkg::CfgDataW-1:0] cfg_data
);
  import uhcw_pkg::*;

  // configuration registers
  logic [31:0] confirm_ms_r;
  logic [31:0] give_up_ms_r;
  logic [31:0] self_check_ms_r;
  logic [31:0] http_fresh_ms_r;
  logic        link_required_r;

  // watchdog state
  logic        pending_r;
  logic [31:0] start_time_r;
  logic        healthy_r;
  logic [31:0] healthy_since_r;
  logic        checked_r;
  logic        passed_r;
  logic [31:0] check_time_r;
  logic [2:0]  missing_r;

  // pipeline registers
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      advance;

  // next-state values
  logic        pending_nxt;
  logic [31:0] start_time_nxt;
  logic        healthy_nxt;
  logic [31:0] healthy_since_nxt;
  logic        checked_nxt;
  logic        passed_nxt;
  logic [31:0] check_time_nxt;
  logic [2:0]  missing_nxt;
  out_item_t   out_item_nxt;

  assign cfg_ready = 1'b1;

  // Move the held event on whenever the output register is free or being drained.
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_comb begin
    logic        is_begin;
    logic        is_check;
    logic        is_update;
    logic        is_confirm;
    logic        link_missing;
    logic        fresh_pre;
    logic        h;
    logic        restart_health;
    logic [31:0] now;
    logic [31:0] up_age;
    logic [31:0] hs_age;
    logic [31:0] ct_age;
    logic [31:0] ct_age_pre;
    logic [31:0] hs_age_pre;

    now        = in_item_r.now_ms;
    is_begin   = (in_item_r.action == ACT_BEGIN);
    is_check   = (in_item_r.action == ACT_SELF_CHECK);
    is_update  = (in_item_r.action == ACT_UPDATE);
    is_confirm = (in_item_r.action == ACT_CONFIRM);
    link_missing = link_required_r && !in_item_r.link_up;

    ct_age_pre = now - check_time_r;
    hs_age_pre = now - healthy_since_r;
    // begin restarts every timer at now, so ages measured from it are zero
    up_age     = is_begin ? 32'd0 : (now - start_time_r);
    fresh_pre  = checked_r && passed_r && (ct_age_pre < http_fresh_ms_r);

    h = in_item_r.net_ok && fresh_pre && !link_missing;
    restart_health = is_update && pending_r && h && !healthy_r;

    pending_nxt       = pending_r;
    start_time_nxt    = start_time_r;
    healthy_nxt       = healthy_r;
    healthy_since_nxt = healthy_since_r;
    checked_nxt       = checked_r;
    passed_nxt        = passed_r;
    check_time_nxt    = check_time_r;
    missing_nxt       = missing_r;

    out_item_nxt           = '0;
    out_item_nxt.decision  = DEC_NONE;
    out_item_nxt.confirmed = 1'b0;

    hs_age = (is_begin || restart_health) ? 32'd0 : hs_age_pre;
    ct_age = (is_begin || is_check) ? 32'd0 : ct_age_pre;

    if (is_begin) begin
      pending_nxt       = in_item_r.pending_verify;
      start_time_nxt    = now;
      healthy_nxt       = 1'b0;
      healthy_since_nxt = now;
      checked_nxt       = 1'b0;
      passed_nxt        = 1'b0;
      check_time_nxt    = now;
      missing_nxt       = '0;
    end else if (is_check) begin
      checked_nxt    = 1'b1;
      passed_nxt     = in_item_r.check_ok;
      check_time_nxt = now;
      // a failed check drops health even when nothing is pending
      if (!in_item_r.check_ok) begin
        healthy_nxt = 1'b0;
      end
    end else if (is_update) begin
      if (!pending_r) begin
        out_item_nxt.decision = DEC_NOT_PENDING;
      end else begin
        missing_nxt = {link_missing, !fresh_pre, !in_item_r.net_ok};
        healthy_nxt = h;
        if (restart_health) begin
          healthy_since_nxt = now;
        end
        // mark-valid wins over rollback when both hold
        if (h && (hs_age >= confirm_ms_r)) begin
          pending_nxt           = 1'b0;
          out_item_nxt.decision = DEC_MARK_VALID;
        end else if (up_age >= give_up_ms_r) begin
          pending_nxt           = 1'b0;
          out_item_nxt.decision = DEC_ROLLBACK;
        end else begin
          out_item_nxt.decision = DEC_WAIT;
        end
      end
    end else if (is_confirm) begin
      if (pending_r && in_item_r.user_requested && in_item_r.net_ok && !link_missing) begin
        pending_nxt            = 1'b0;
        out_item_nxt.confirmed = 1'b1;
      end
    end

    // status after the event
    out_item_nxt.pending        = pending_nxt;
    out_item_nxt.self_check_due = pending_nxt && in_item_r.web_started &&
                                  (!checked_nxt || (ct_age >= self_check_ms_r));
    out_item_nxt.http_ok        = checked_nxt && passed_nxt && (ct_age < http_fresh_ms_r);
    out_item_nxt.missing_checks = missing_nxt;
    out_item_nxt.healthy_for_ms = (pending_nxt && healthy_nxt) ? hs_age : 32'd0;
    out_item_nxt.remaining_ms   = (pending_nxt && (up_age < give_up_ms_r)) ?
                                  (give_up_ms_r - up_age) : 32'd0;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      confirm_ms_r    <= 32'd60000;
      give_up_ms_r    <= 32'd300000;
      self_check_ms_r <= 32'd30000;
      http_fresh_ms_r <= 32'd60000;
      link_required_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CONFIRM_MS:    confirm_ms_r    <= cfg_data;
        REG_GIVE_UP_MS:    give_up_ms_r    <= cfg_data;
        REG_SELF_CHECK_MS: self_check_ms_r <= cfg_data;
        REG_HTTP_FRESH_MS: http_fresh_ms_r <= cfg_data;
        REG_LINK_REQUIRED: link_required_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // watchdog state, committed as the event moves to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r       <= 1'b0;
      start_time_r    <= '0;
      healthy_r       <= 1'b0;
      healthy_since_r <= '0;
      checked_r       <= 1'b0;
      passed_r        <= 1'b0;
      check_time_r    <= '0;
      missing_r       <= '0;
    end else if (advance) begin
      pending_r       <= pending_nxt;
      start_time_r    <= start_time_nxt;
      healthy_r       <= healthy_nxt;
      healthy_since_r <= healthy_since_nxt;
      checked_r       <= checked_nxt;
      passed_r        <= passed_nxt;
      check_time_r    <= check_time_nxt;
      missing_r       <= missing_nxt;
    end
  end

  // input register: take a word whenever it is empty or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_data;
    end
  end

  // output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

// ----- tb/sv/uhcw_checker.sv -----
`timescale 1ns / 1ps

module uhcw_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  uhcw_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  uhcw_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [uhcw_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [uhcw_pkg::CfgDataW-1:0] cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  import uhcw_pkg::*;

  // register copies
  logic [31:0] confirm_need;
  logic [31:0] give_up_after;
  logic [31:0] check_every;
  logic [31:0] fresh_window;
  logic        link_needed;

  // watchdog state
  logic        awaiting;
  logic [31:0] t_begin;
  logic        is_healthy;
  logic [31:0] t_healthy;
  logic        have_check;
  logic        last_check_ok;
  logic [31:0] t_check;
  logic [2:0]  missing;

  out_item_t   expected_status[$];
  out_item_t   want;

  function automatic logic check_is_fresh(logic [31:0] now);
    logic [31:0] check_age;
    check_age = now - t_check;
    return have_check && last_check_ok && (check_age < fresh_window);
  endfunction

  // Advance the watchdog by one event and return the status word it yields.
  function automatic out_item_t judge_event(in_item_t ev);
    out_item_t   res;
    logic [31:0] now;
    logic [31:0] healthy_age;
    logic [31:0] up;
    logic [31:0] check_age;
    logic        link_missing;
    res          = '0;
    now          = ev.now_ms;
    link_missing = link_needed && !ev.link_up;
    case (ev.action)
      ACT_BEGIN: begin
        awaiting      = ev.pending_verify;
        t_begin       = now;
        is_healthy    = 1'b0;
        t_healthy     = now;
        have_check    = 1'b0;
        last_check_ok = 1'b0;
        t_check       = now;
        missing       = '0;
      end
      ACT_SELF_CHECK: begin
        have_check    = 1'b1;
        last_check_ok = ev.check_ok;
        t_check       = now;
        if (!ev.check_ok) is_healthy = 1'b0;
      end
      ACT_UPDATE: begin
        if (!awaiting) begin
          res.decision = DEC_NOT_PENDING;
        end else begin
          missing = {link_missing, !check_is_fresh(now), !ev.net_ok};
          if (missing == '0 && !is_healthy) t_healthy = now;
          is_healthy  = (missing == '0);
          healthy_age = now - t_healthy;
          up          = now - t_begin;
          if (is_healthy && healthy_age >= confirm_need) begin
            awaiting     = 1'b0;
            res.decision = DEC_MARK_VALID;
          end else if (up >= give_up_after) begin
            awaiting     = 1'b0;
            res.decision = DEC_ROLLBACK;
          end else begin
            res.decision = DEC_WAIT;
          end
        end
      end
      ACT_CONFIRM: begin
        if (awaiting && ev.user_requested && ev.net_ok && !link_missing) begin
          awaiting      = 1'b0;
          res.confirmed = 1'b1;
        end
      end
      default: ;
    endcase
    check_age          = now - t_check;
    up                 = now - t_begin;
    res.pending        = awaiting;
    res.self_check_due = awaiting && ev.web_started && (!have_check || check_age >= check_every);
    res.http_ok        = check_is_fresh(now);
    res.missing_checks = missing;
    res.healthy_for_ms = (awaiting && is_healthy) ? now - t_healthy : '0;
    res.remaining_ms   = (awaiting && up < give_up_after) ? give_up_after - up : '0;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (exp_val !== got_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, name, exp_val, got_val);
    end
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      confirm_need  = 32'd60000;
      give_up_after = 32'd300000;
      check_every   = 32'd30000;
      fresh_window  = 32'd60000;
      link_needed   = 1'b0;
      awaiting      = 1'b0;
      t_begin       = '0;
      is_healthy    = 1'b0;
      t_healthy     = '0;
      have_check    = 1'b0;
      last_check_ok = 1'b0;
      t_check       = '0;
      missing       = '0;
      expected_status.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CONFIRM_MS:    confirm_need  = cfg_data;
          REG_GIVE_UP_MS:    give_up_after = cfg_data;
          REG_SELF_CHECK_MS: check_every   = cfg_data;
          REG_HTTP_FRESH_MS: fresh_window  = cfg_data;
          REG_LINK_REQUIRED: link_needed   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_status.push_back(judge_event(in_data));
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected status word %0h", $realtime, out_data);
        end else begin
          want = expected_status.pop_front();
          check_field("decision", 32'(want.decision), 32'(out_data.decision));
          check_field("confirmed", 32'(want.confirmed), 32'(out_data.confirmed));
          check_field("pending", 32'(want.pending), 32'(out_data.pending));
          check_field("self_check_due", 32'(want.self_check_due),
                      32'(out_data.self_check_due));
          check_field("http_ok", 32'(want.http_ok), 32'(out_data.http_ok));
          check_field("missing_checks", 32'(want.missing_checks),
                      32'(out_data.missing_checks));
          check_field("healthy_for_ms", want.healthy_for_ms, out_data.healthy_for_ms);
          check_field("remaining_ms", want.remaining_ms, out_data.remaining_ms);
        end
      end
    end
    outstanding = expected_status.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import uhcw_pkg::*;

  // Action codes 5..7 are unassigned; the block must treat them as a query.
  localparam logic [ActionW-1:0] ACT_SPARE_5 = 3'd5;
  localparam logic [ActionW-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ActionW-1:0] ACT_SPARE_7 = 3'd7;
  // Register index past the list: writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] REG_UNUSED  = 3'd7;

  localparam int unsigned STALL_LIMIT = 1000;  // cycles without any handshake
  localparam int unsigned BACKLOG_LEN = 64;    // long receiver hold-off
  localparam int unsigned DRAIN_WAIT  = 8;     // settle margin after the last status word

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int                  mismatches;
  int                  outstanding;

  // Stimulus-side bookkeeping.
  logic [31:0]         stamp_ms;        // running millisecond clock of the event stream
  logic [31:0]         step_max;        // largest jump of stamp_ms between events
  bit                  quiet = 1'b0;    // both sides stop idling while set
  int unsigned         words_sent = 0;
  int unsigned         hold_left  = 0;
  bit                  backlog_done = 1'b0;

  always #1 clk = ~clk;

  update_health_confirm_watchdog u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  uhcw_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Receiver: stall at random about 16% of cycles, never while quiet is set.
  // Once, well into the run, hold the output off for a long stretch so the
  // pipeline fills and the block has to push back on its input.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (rst_n && !backlog_done && words_sent >= 700) begin
      backlog_done <= 1'b1;
      hold_left    <= BACKLOG_LEN - 1;
      out_stall    <= 1'b1;
    end else if (!rst_n || quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 16);
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long.
  wire moved = (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready);

  initial begin
    int unsigned still;
    still = 0;
    while (still < STALL_LIMIT) begin
      @(posedge clk);
      if (moved) still = 0;
      else still++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic in_item_t make_ev(logic [ActionW-1:0] act, logic [31:0] now, logic pv,
                                       logic web, logic ok, logic net, logic link, logic user);
    in_item_t ev;
    ev.action         = act;
    ev.now_ms         = now;
    ev.pending_verify = pv;
    ev.web_started    = web;
    ev.check_ok       = ok;
    ev.net_ok         = net;
    ev.link_up        = link;
    ev.user_requested = user;
    return ev;
  endfunction

  // Offer one event word; idle first at random, then hold it until taken.
  // Valid stays high on return so back-to-back words need no re-raise.
  task automatic send_word(in_item_t ev);
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_watchdog(logic [31:0] confirm, logic [31:0] give_up,
                                  logic [31:0] interval, logic [31:0] fresh,
                                  logic [31:0] link_word);
    write_reg(REG_CONFIRM_MS, confirm);
    write_reg(REG_GIVE_UP_MS, give_up);
    write_reg(REG_SELF_CHECK_MS, interval);
    write_reg(REG_HTTP_FRESH_MS, fresh);
    write_reg(REG_LINK_REQUIRED, link_word);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, then wait until every status word is back so the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  // Build one random event. Most words belong to a plausible verification
  // session with time moving forward; a few are pure noise.
  function automatic in_item_t next_event();
    in_item_t    ev;
    int unsigned pick;
    ev.action         = ACT_QUERY;
    ev.now_ms         = $urandom;
    ev.pending_verify = 1'($urandom_range(1));
    ev.web_started    = 1'($urandom_range(1));
    ev.check_ok       = 1'($urandom_range(1));
    ev.net_ok         = 1'($urandom_range(1));
    ev.link_up        = 1'($urandom_range(1));
    ev.user_requested = 1'($urandom_range(1));
    if ($urandom_range(99) < 8) begin
      ev.action = 3'($urandom_range(7));
      return ev;
    end
    stamp_ms  = stamp_ms + ((step_max == 32'hFFFF_FFFF) ? $urandom : $urandom_range(step_max));
    ev.now_ms = stamp_ms;
    pick = $urandom_range(99);
    if (pick < 6) begin
      ev.action         = ACT_BEGIN;
      ev.pending_verify = ($urandom_range(9) != 0);
      // start some sessions just short of the 32-bit wrap
      if ($urandom_range(3) == 0) begin
        stamp_ms  = 32'hFFFF_FFFF - $urandom_range(2000);
        ev.now_ms = stamp_ms;
      end
    end else if (pick < 26) begin
      ev.action   = ACT_SELF_CHECK;
      ev.check_ok = ($urandom_range(99) < 85);
    end else if (pick < 71) begin
      ev.action  = ACT_UPDATE;
      ev.net_ok  = ($urandom_range(99) < 90);
      ev.link_up = ($urandom_range(99) < 85);
    end else if (pick < 81) begin
      ev.action  = ACT_CONFIRM;
      ev.net_ok  = ($urandom_range(99) < 80);
      ev.link_up = ($urandom_range(99) < 80);
    end else if (pick < 97) begin
      ev.action = ACT_QUERY;
    end else begin
      case ($urandom_range(2))
        0:       ev.action = ACT_SPARE_5;
        1:       ev.action = ACT_SPARE_6;
        default: ev.action = ACT_SPARE_7;
      endcase
    end
    return ev;
  endfunction

  task automatic random_events(int unsigned count, logic [31:0] max_step);
    step_max = max_step;
    repeat (count) send_word(next_event());
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    stamp_ms  = '0;
    step_max  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset register values (60 s confirm, 300 s give-up).
    // Nothing pending yet: update says not-pending, confirm is refused.
    send_word(make_ev(ACT_QUERY, 32'd0, 0, 1, 0, 0, 0, 0));
    send_word(make_ev(ACT_UPDATE, 32'd5, 1, 1, 1, 1, 1, 1));
    send_word(make_ev(ACT_CONFIRM, 32'd6, 1, 1, 1, 1, 1, 1));
    // Session straddling the timestamp wrap, ending in mark-valid.
    send_word(make_ev(ACT_BEGIN, 32'hFFFF_F000, 1, 1, 0, 1, 1, 0));
    send_word(make_ev(ACT_QUERY, 32'hFFFF_F010, 0, 1, 0, 0, 0, 0));
    send_word(make_ev(ACT_UPDATE, 32'hFFFF_F020, 0, 1, 0, 0, 1, 0));
    send_word(make_ev(ACT_SELF_CHECK, 32'hFFFF_F100, 0, 1, 1, 0, 0, 0));
    send_word(make_ev(ACT_UPDATE, 32'hFFFF_F200, 0, 1, 0, 1, 0, 0));
    send_word(make_ev(ACT_SELF_CHECK, 32'hFFFF_F200 + 32'd40000, 0, 1, 1, 0, 0, 0));
    send_word(make_ev(ACT_UPDATE, 32'hFFFF_F200 + 32'd60000, 0, 1, 0, 1, 0, 0));
    // Failed self check keeps the session unhealthy until give-up: rollback.
    send_word(make_ev(ACT_BEGIN, 32'd0, 1, 0, 0, 0, 0, 0));
    send_word(make_ev(ACT_SELF_CHECK, 32'd10, 0, 1, 0, 1, 1, 0));
    send_word(make_ev(ACT_UPDATE, 32'd20, 0, 1, 0, 1, 1, 0));
    send_word(make_ev(ACT_UPDATE, 32'd300000, 0, 1, 0, 1, 1, 0));
    // Confirm-before-restart: refused without request, refused with net down,
    // then accepted.
    send_word(make_ev(ACT_BEGIN, 32'd400000, 1, 1, 0, 0, 0, 0));
    send_word(make_ev(ACT_SELF_CHECK, 32'd400010, 0, 1, 1, 0, 0, 0));
    send_word(make_ev(ACT_CONFIRM, 32'd400020, 0, 1, 0, 1, 1, 0));
    send_word(make_ev(ACT_CONFIRM, 32'd400030, 0, 1, 0, 0, 1, 1));
    send_word(make_ev(ACT_CONFIRM, 32'd400040, 0, 1, 0, 1, 1, 1));
    // Unassigned action codes with every bit set act as a query.
    send_word(make_ev(ACT_SPARE_5, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1));
    send_word(make_ev(ACT_SPARE_6, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1));
    send_word(make_ev(ACT_SPARE_7, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1));
    // Begin without pending; a failed check and an update change nothing pending.
    send_word(make_ev(ACT_BEGIN, 32'd500000, 0, 1, 0, 0, 0, 0));
    send_word(make_ev(ACT_SELF_CHECK, 32'd500100, 0, 1, 0, 0, 0, 0));
    send_word(make_ev(ACT_UPDATE, 32'd500200, 0, 1, 0, 1, 1, 0));
    stamp_ms = 32'd500300;

    // Random sessions at reset register values, steps of up to 15 s.
    random_events(300, 32'd15000);

    // Short windows so sessions end within a few dozen events; no idling.
    drain();
    write_reg(REG_UNUSED, $urandom);
    program_watchdog(32'd200, 32'd1000, 32'd100, 32'd300, 32'd0);
    quiet = 1'b1;
    random_events(320, 32'd120);
    quiet = 1'b0;

    // Same scale with the secondary link required; the long hold-off lands here.
    drain();
    program_watchdog(32'd150, 32'd800, 32'd60, 32'd250, 32'd1);
    random_events(320, 32'd100);

    // All windows zero: every update decides at once, checks are never fresh.
    drain();
    program_watchdog(32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
    random_events(300, 32'd5);

    // All windows at maximum with full-range jumps; link bit clear, upper bits set.
    drain();
    program_watchdog(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFE);
    random_events(300, 32'hFFFF_FFFF);

    // Instant confirm, never give up, checks due every ms, link required.
    drain();
    program_watchdog(32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_events(300, 32'd50);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- update_health_confirm_watchdog.f -----
hw/rtl/uhcw_pkg.sv
hw/rtl/update_health_confirm_watchdog.sv
tb/sv/uhcw_checker.sv
tb/sv/tb.sv
